// ----- src/sgm_pkg.sv -----
// ============================================================================
// sgm_pkg: shared definitions for the Sobel gradient magnitude core
// Sizes, derived widths, register indexes, the pipeline tag and the square
// root cell payload.
// ============================================================================
package sgm_pkg;

  // Frame and sample limits.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int MIN_SIZE    = 3;

  // Register and coordinate widths.
  localparam int SIZE_W      = 11;
  localparam int COORD_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W   = 1;

  // Arithmetic widths: kernel sums, signed gradients, squares and root.
  localparam int ABS_W       = SAMPLE_W + 2;
  localparam int GRAD_W      = ABS_W + 1;
  localparam int SQ_W        = 2 * ABS_W;
  localparam int MAG_W       = ABS_W + 1;
  localparam int RAD_W       = 2 * MAG_W;
  localparam int REM_W       = MAG_W + 2;
  localparam int MAG_MAX     = 370723;

  // Stream widths.
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = COORD_W + ROW_W + MAG_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Position and frame-end flag that travel with each interior pixel.
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [ROW_W-1:0]   cy;
    logic               last;
  } sgm_tag_t;

  // Working set of one digit-recurrence square root step.
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] root;
  } sgm_sqrt_t;

  // Limits a size register to the range the line stores support.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < SIZE_W'(MIN_SIZE)) begin
      res = SIZE_W'(MIN_SIZE);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

// ----- src/sgm_line_store.sv -----
// ============================================================================
// sgm_line_store: two row buffers of the Sobel window
// Holds the row two above and the row one above. One read address serves
// both; the middle row is overwritten at that address with the new sample,
// and the upper row is then written with the old middle value once it is read out.
// ============================================================================
module sgm_line_store (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [sgm_pkg::COORD_W-1:0]   rd_addr_i,
  input  logic [sgm_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          upper_wr_en_i,
  input  logic [sgm_pkg::COORD_W-1:0]   upper_wr_addr_i,
  input  logic [sgm_pkg::SAMPLE_W-1:0]  upper_wr_data_i,
  output logic [sgm_pkg::SAMPLE_W-1:0]  upper_rd_o,
  output logic [sgm_pkg::SAMPLE_W-1:0]  middle_rd_o
);
  import sgm_pkg::*;

  logic [SAMPLE_W-1:0] upper_mem  [MAX_WIDTH];
  logic [SAMPLE_W-1:0] middle_mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0] upper_rd_q;
  logic [SAMPLE_W-1:0] middle_rd_q;

  // Middle row: read the old value and store the new sample in one access.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      middle_rd_q            <= middle_mem[rd_addr_i];
      middle_mem[rd_addr_i]  <= sample_i;
    end
  end

  // Upper row: read with the middle row, written back once the middle value is read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      upper_rd_q <= upper_mem[rd_addr_i];
    end
    if (upper_wr_en_i) begin
      upper_mem[upper_wr_addr_i] <= upper_wr_data_i;
    end
  end

  assign upper_rd_o  = upper_rd_q;
  assign middle_rd_o = middle_rd_q;

endmodule

// ----- src/sgm_sqrt_cell.sv -----
// ============================================================================
// sgm_sqrt_cell: one digit of the integer square root chain
// Brings down two radicand bits, tries the next root bit and hands the
// updated remainder, root and shifted radicand to the next cell.
// ============================================================================
module sgm_sqrt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  sgm_pkg::sgm_tag_t     tag_i,
  input  sgm_pkg::sgm_sqrt_t    data_i,
  output logic                  valid_o,
  output sgm_pkg::sgm_tag_t     tag_o,
  output sgm_pkg::sgm_sqrt_t    data_o
);
  import sgm_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;
  logic [REM_W+1:0] rem_sub;
  sgm_sqrt_t        data_d;
  sgm_sqrt_t        data_q;
  sgm_tag_t         tag_q;
  logic             valid_q;

  // Trial subtraction of (4 * root + 1) from the extended remainder.
  always_comb begin
    rem_sh      = {data_i.rem, data_i.rad[RAD_W-1 -: 2]};
    trial       = (REM_W + 2)'({data_i.root, 2'b01});
    take        = (rem_sh >= trial);
    rem_sub     = rem_sh - trial;
    data_d.rad  = {data_i.rad[RAD_W-3:0], 2'b00};
    data_d.rem  = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    data_d.root = {data_i.root[MAG_W-2:0], take};
  end

  // Valid bit of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload of the cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign data_o  = data_q;

  // The remainder never exceeds twice the partial root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((REM_W)'(data_q.rem) <= (REM_W)'({data_q.root, 1'b0})))
    else $error("sqrt cell remainder out of bound");

endmodule

// ----- src/sobel_gradient_magnitude_core.sv -----
// ============================================================================
// sobel_gradient_magnitude_core: streaming 3x3 Sobel gradient magnitude
// Takes height samples in raster order and emits floor(sqrt(gx^2 + gy^2))
// for every interior pixel, with its coordinates and a frame-end flag.
// ============================================================================
//
// Usage:
//   Samples enter on the s_axis channel, one per beat, in raster order.
//   Image width and height are set through the cfg channel (index 0 and 1)
//   while the core is idle; values outside 3..1024 are clamped.
//   Only interior pixels produce a beat on m_axis; border samples are
//   absorbed. tlast marks the last interior pixel of a frame.
//   From an accepted sample to its result beat the data passes through
//   five front stages (line store read, window, kernel sums, squares,
//   sum), nineteen square root cells of one result bit each, and the
//   output register.
//   Throughput, unless stalled, is one sample per cycle; the pipelined
//   root chain lets the line store port and the cell chain each take one beat per cycle.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and s_axis_tready falls until the result is taken.
//   After reset the size registers read 1024, the window is zero and the
//   frame position is the top-left pixel; the line stores are not cleared,
//   and entries read before they are written feed only border samples.
//
module sobel_gradient_magnitude_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sgm_pkg::SIZE_W-1:0]       cfg_data_i,
  // Sample input: tdata[15:0] height_sample.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sgm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result output: tdata[9:0] center_x, [19:10] center_y,
  // [38:20] gradient_magnitude, [39] zero; tlast is last_of_frame.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sgm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast
);
  import sgm_pkg::*;

  // Size registers and frame position.
  logic [SIZE_W-1:0]  width_q, height_q;
  logic [COORD_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;

  // Front stage signals.
  logic               advance;
  logic               accept;
  logic [SIZE_W-1:0]  row_pre, row_wrap, col_inc, row_inc;
  logic [COORD_W-1:0] cur_c;
  logic [ROW_W-1:0]   cur_r;
  logic               cur_emit;
  sgm_tag_t           cur_tag;

  // Stage 1: line store data available.
  logic                s1_valid_q;
  logic                s1_emit_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [COORD_W-1:0]  s1_col_q;
  sgm_tag_t            s1_tag_q;
  logic [SAMPLE_W-1:0] upper_rd, middle_rd;

  // Stage 2: window, Sobel sums.
  logic [SAMPLE_W-1:0] win_q [3][3];
  logic                s2_valid_q;
  sgm_tag_t            s2_tag_q;
  logic [ABS_W-1:0]    pos_x, neg_x, pos_y, neg_y;
  logic signed [GRAD_W-1:0] gx_d, gy_d;

  // Stage 3: gradients; stage 4: squares; stage 5: radicand.
  logic                     s3_valid_q;
  sgm_tag_t                 s3_tag_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic [GRAD_W-1:0]        gx_neg, gy_neg;
  logic [ABS_W-1:0]         ax, ay;
  logic                     s4_valid_q;
  sgm_tag_t                 s4_tag_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic                     s5_valid_q;
  sgm_tag_t                 s5_tag_q;
  logic [RAD_W-1:0]         rad_q;

  // Square root chain.
  logic      cell_valid [MAG_W+1];
  sgm_tag_t  cell_tag   [MAG_W+1];
  sgm_sqrt_t cell_data  [MAG_W+1];

  // Output register.
  logic             out_valid_q;
  sgm_tag_t         out_tag_q;
  logic [MAG_W-1:0] out_mag_q;

  // The chain moves unless a result waits for a stalled receiver.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;
  assign cfg_ready_o   = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(MAX_WIDTH);
      height_q <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= clamp_size(cfg_data_i, SIZE_W'(MAX_WIDTH));
        REG_IMAGE_HEIGHT: height_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // Position of the incoming sample and of the one after it.
  always_comb begin
    if (SIZE_W'(col_q) >= width_q) begin
      cur_c   = '0;
      row_pre = SIZE_W'(row_q) + SIZE_W'(1);
    end else begin
      cur_c   = col_q;
      row_pre = SIZE_W'(row_q);
    end
    row_wrap = (row_pre >= height_q) ? '0 : row_pre;
    cur_r    = row_wrap[ROW_W-1:0];

    cur_emit     = (cur_c >= COORD_W'(2)) && (cur_r >= ROW_W'(2));
    cur_tag.cx   = cur_c - COORD_W'(1);
    cur_tag.cy   = cur_r - ROW_W'(1);
    cur_tag.last = (SIZE_W'(cur_c) == width_q - SIZE_W'(1)) &&
                   (SIZE_W'(cur_r) == height_q - SIZE_W'(1));

    col_inc = SIZE_W'(cur_c) + SIZE_W'(1);
    row_inc = SIZE_W'(cur_r) + SIZE_W'(1);
    if (col_inc >= width_q) begin
      col_d = '0;
      row_d = (row_inc >= height_q) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COORD_W-1:0];
      row_d = cur_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Row buffers.
  sgm_line_store u_line_store (
    .clk_i           (clk_i),
    .rd_en_i         (accept),
    .rd_addr_i       (cur_c),
    .sample_i        (s_axis_tdata[SAMPLE_W-1:0]),
    .upper_wr_en_i   (advance && s1_valid_q),
    .upper_wr_addr_i (s1_col_q),
    .upper_wr_data_i (middle_rd),
    .upper_rd_o      (upper_rd),
    .middle_rd_o     (middle_rd)
  );

  // Stage 1 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q   <= cur_emit;
      s1_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      s1_col_q    <= cur_c;
      s1_tag_q    <= cur_tag;
    end
  end

  // Window shift: column 2 takes the newest column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (advance && s1_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= upper_rd;
      win_q[1][2] <= middle_rd;
      win_q[2][2] <= s1_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_tag_q <= s1_tag_q;
    end
  end

  // Sobel X and Y kernels as weighted column and row sums.
  always_comb begin
    pos_x = ABS_W'(win_q[0][2]) + ABS_W'({win_q[1][2], 1'b0}) + ABS_W'(win_q[2][2]);
    neg_x = ABS_W'(win_q[0][0]) + ABS_W'({win_q[1][0], 1'b0}) + ABS_W'(win_q[2][0]);
    pos_y = ABS_W'(win_q[2][0]) + ABS_W'({win_q[2][1], 1'b0}) + ABS_W'(win_q[2][2]);
    neg_y = ABS_W'(win_q[0][0]) + ABS_W'({win_q[0][1], 1'b0}) + ABS_W'(win_q[0][2]);
    gx_d  = signed'({1'b0, pos_x}) - signed'({1'b0, neg_x});
    gy_d  = signed'({1'b0, pos_y}) - signed'({1'b0, neg_y});
  end

  // Magnitudes of the gradients.
  always_comb begin
    gx_neg = -gx_q;
    gy_neg = -gy_q;
    ax     = gx_q[GRAD_W-1] ? gx_neg[ABS_W-1:0] : gx_q[ABS_W-1:0];
    ay     = gy_q[GRAD_W-1] ? gy_neg[ABS_W-1:0] : gy_q[ABS_W-1:0];
  end

  // Stages 3 to 5 valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // Stages 3 to 5 payload: gradients, squares, radicand.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      s3_tag_q <= s2_tag_q;
      sqx_q    <= SQ_W'(ax * ax);
      sqy_q    <= SQ_W'(ay * ay);
      s4_tag_q <= s3_tag_q;
      rad_q    <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
      s5_tag_q <= s4_tag_q;
    end
  end

  // Square root chain, one result bit per cell.
  assign cell_valid[0]     = s5_valid_q;
  assign cell_tag[0]       = s5_tag_q;
  assign cell_data[0].rad  = rad_q;
  assign cell_data[0].rem  = '0;
  assign cell_data[0].root = '0;

  for (genvar k = 0; k < MAG_W; k++) begin : g_cell
    sgm_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (cell_valid[k]),
      .tag_i   (cell_tag[k]),
      .data_i  (cell_data[k]),
      .valid_o (cell_valid[k+1]),
      .tag_o   (cell_tag[k+1]),
      .data_o  (cell_data[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= cell_valid[MAG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_tag_q <= cell_tag[MAG_W];
      out_mag_q <= cell_data[MAG_W].root;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_mag_q, out_tag_q.cy, out_tag_q.cx};
  assign m_axis_tlast  = out_tag_q.last;

  // A result always names an interior pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_tag_q.cx != '0) && (out_tag_q.cy != '0))
    else $error("result at a border coordinate");

  // The magnitude stays within the largest Sobel response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mag_q <= MAG_W'(MAG_MAX)))
    else $error("gradient magnitude out of range");

  // An emitting beat in stage 1 carries the column one left of its sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_emit_q) |-> (s1_tag_q.cx == s1_col_q - COORD_W'(1)))
    else $error("stage 1 tag does not match its column");

endmodule
